/* design/vsc_pkg.sv */
// Shared types, widths and the power table of the vector sine contrast block.
package vsc_pkg;

  localparam int POWER_TABLE_ENTRIES  = 256;
  localparam int RESULT_FRACTION_BITS = 16;

  localparam int HUE_W   = 16;
  localparam int GAIN_W  = 8;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd65;
  localparam int X_W     = 24;
  localparam int SQ_W    = 48;
  localparam int CROSS_W = 41;
  localparam int HALF_W  = 24;
  localparam int WIDE_W  = 96;
  localparam int QUOT_W  = 33;
  localparam int SINE_W  = 17;
  localparam int SINE_FRAC = 16;
  localparam int OUT_W   = 16;

  localparam int IDX_W   = $clog2(POWER_TABLE_ENTRIES);
  localparam int TAB_W   = RESULT_FRACTION_BITS + 1;
  localparam int P_W     = SINE_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POWER_TABLE_ENTRIES - 1);
  localparam logic [TAB_W-1:0] RES_MAX = TAB_W'((1 << RESULT_FRACTION_BITS) - 1);
  localparam logic [255:0] TableDen =
    256'(POWER_TABLE_ENTRIES - 1) * 256'(POWER_TABLE_ENTRIES - 1);

  typedef struct packed {
    logic valid;
    logic degen;
  } vsc_tag_t;

  typedef logic [TAB_W-1:0] pow_tab_t [POWER_TABLE_ENTRIES];

  function automatic pow_tab_t build_pow_table();
    pow_tab_t    tab;
    logic [255:0] target;
    logic [255:0] cand;
    logic [255:0] p5;
    logic [TAB_W-1:0] t;
    for (int i = 0; i < POWER_TABLE_ENTRIES; i++) begin
      target = ((256'(i) * 256'(i)) << (5 * RESULT_FRACTION_BITS)) / TableDen;
      t = '0;
      for (int b = TAB_W - 1; b >= 0; b--) begin
        cand = 256'(t | (TAB_W'(1) << b));
        p5 = cand * cand * cand * cand * cand;
        if (p5 <= target) begin
          t = cand[TAB_W-1:0];
        end
      end
      tab[i] = t;
    end
    return tab;
  endfunction

  localparam pow_tab_t POW_TABLE = build_pow_table();

endpackage

/* design/vector_sine_contrast.sv */
// Top level of the vector sine contrast block.
// Takes one transaction every clock cycle (busy stays low) and presents each result
// on strobe_o once its start has passed through 5 front stages (gain, products,
// lengths, wide products), 33 divider stages (one quotient bit each), 17 square-root
// stages (one root bit each) and 4 power-curve stages. Results cannot be held off.
module vector_sine_contrast import vsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [HUE_W-1:0] first_hue_i,
  input  logic signed [HUE_W-1:0] second_hue_i,
  input  logic signed [HUE_W-1:0] first_value_i,
  input  logic signed [HUE_W-1:0] second_value_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [GAIN_W-1:0]       cfg_data_i,
  output logic                    strobe_o,
  output logic [OUT_W-1:0]        contrast_out_o,
  output logic                    degenerate_o
);

  logic [GAIN_W-1:0] gain_q;
  vsc_tag_t          in_tag, f_tag, d_tag, s_tag, p_tag;
  logic [WIDE_W-1:0] lsq, csq;
  logic [QUOT_W-1:0] quot;
  logic [SINE_W-1:0] sine;
  logic [OUT_W-1:0]  contrast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_valid_i) begin
      gain_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign busy         = 1'b0;
  assign in_tag.valid = start;
  assign in_tag.degen = 1'b0;

  vsc_front u_front (
    .clk_i,
    .rst_ni,
    .gain_i         (gain_q),
    .tag_i          (in_tag),
    .first_hue_i,
    .second_hue_i,
    .first_value_i,
    .second_value_i,
    .tag_o          (f_tag),
    .lsq_o          (lsq),
    .csq_o          (csq)
  );

  vsc_divider u_div (
    .clk_i,
    .rst_ni,
    .tag_i  (f_tag),
    .num_i  (csq),
    .den_i  (lsq),
    .tag_o  (d_tag),
    .quot_o (quot)
  );

  vsc_isqrt u_sqrt (
    .clk_i,
    .rst_ni,
    .tag_i  (d_tag),
    .rad_i  (quot),
    .tag_o  (s_tag),
    .root_o (sine)
  );

  vsc_power u_pow (
    .clk_i,
    .rst_ni,
    .tag_i      (s_tag),
    .sine_i     (sine),
    .tag_o      (p_tag),
    .contrast_o (contrast)
  );

  assign strobe_o       = p_tag.valid;
  assign degenerate_o   = p_tag.degen;
  assign contrast_out_o = contrast;

endmodule

/* design/vsc_front.sv */
// Front pipeline: hue scaling, squares and cross terms, squared lengths and wide products.
module vsc_front import vsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [GAIN_W-1:0]        gain_i,
  input  vsc_tag_t                 tag_i,
  input  logic signed [HUE_W-1:0]  first_hue_i,
  input  logic signed [HUE_W-1:0]  second_hue_i,
  input  logic signed [HUE_W-1:0]  first_value_i,
  input  logic signed [HUE_W-1:0]  second_value_i,
  output vsc_tag_t                 tag_o,
  output logic [WIDE_W-1:0]        lsq_o,
  output logic [WIDE_W-1:0]        csq_o
);

  // stage 1: scaled hues
  vsc_tag_t t1_q;
  logic signed [X_W-1:0]   x1_q, x2_q;
  logic signed [HUE_W-1:0] y1_q, y2_q;
  logic signed [X_W:0]     x1_full, x2_full;

  assign x1_full = $signed({1'b0, gain_i}) * first_hue_i;
  assign x2_full = $signed({1'b0, gain_i}) * second_hue_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
    end else begin
      t1_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q <= x1_full[X_W-1:0];
    x2_q <= x2_full[X_W-1:0];
    y1_q <= first_value_i;
    y2_q <= second_value_i;
  end

  // stage 2: products
  vsc_tag_t t2_q;
  logic signed [2*X_W-1:0]      xx1_q, xx2_q;
  logic signed [2*HUE_W-1:0]    yy1_q, yy2_q;
  logic signed [X_W+HUE_W-1:0]  x1y2_q, y1x2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t2_q <= '0;
    end else begin
      t2_q <= t1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    xx1_q  <= x1_q * x1_q;
    xx2_q  <= x2_q * x2_q;
    yy1_q  <= y1_q * y1_q;
    yy2_q  <= y2_q * y2_q;
    x1y2_q <= x1_q * y2_q;
    y1x2_q <= y1_q * x2_q;
  end

  // stage 3: squared lengths and absolute cross product
  vsc_tag_t t3_q;
  logic [SQ_W-1:0]    n1_q, n2_q;
  logic [CROSS_W-1:0] c_q;
  logic [SQ_W-1:0]    n1_d, n2_d;
  logic signed [CROSS_W-1:0] cr_d;
  logic [CROSS_W-1:0] c_d;

  assign n1_d = SQ_W'(unsigned'(xx1_q)) + SQ_W'(unsigned'(yy1_q));
  assign n2_d = SQ_W'(unsigned'(xx2_q)) + SQ_W'(unsigned'(yy2_q));
  assign cr_d = {x1y2_q[X_W+HUE_W-1], x1y2_q} - {y1x2_q[X_W+HUE_W-1], y1x2_q};
  assign c_d  = cr_d[CROSS_W-1] ? CROSS_W'(-cr_d) : CROSS_W'(cr_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t3_q <= '0;
    end else begin
      t3_q.valid <= t2_q.valid;
      t3_q.degen <= (n1_d == '0) || (n2_d == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q <= n1_d;
    n2_q <= n2_d;
    c_q  <= c_d;
  end

  // stage 4: partial products
  vsc_tag_t t4_q;
  logic [SQ_W-1:0] ca;
  logic [SQ_W-1:0] l00_q, l01_q, l10_q, l11_q;
  logic [SQ_W-1:0] c00_q, c01_q, c10_q, c11_q;

  assign ca = SQ_W'(c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t4_q <= '0;
    end else begin
      t4_q <= t3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l00_q <= n1_q[HALF_W-1:0]      * n2_q[HALF_W-1:0];
    l01_q <= n1_q[HALF_W-1:0]      * n2_q[SQ_W-1:HALF_W];
    l10_q <= n1_q[SQ_W-1:HALF_W]   * n2_q[HALF_W-1:0];
    l11_q <= n1_q[SQ_W-1:HALF_W]   * n2_q[SQ_W-1:HALF_W];
    c00_q <= ca[HALF_W-1:0]        * ca[HALF_W-1:0];
    c01_q <= ca[HALF_W-1:0]        * ca[SQ_W-1:HALF_W];
    c10_q <= ca[SQ_W-1:HALF_W]     * ca[HALF_W-1:0];
    c11_q <= ca[SQ_W-1:HALF_W]     * ca[SQ_W-1:HALF_W];
  end

  // stage 5: sum partial products
  vsc_tag_t t5_q;
  logic [WIDE_W-1:0] lsq_q, csq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t5_q <= '0;
    end else begin
      t5_q <= t4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lsq_q <= (WIDE_W'(l11_q) << (2 * HALF_W))
           + ((WIDE_W'(l01_q) + WIDE_W'(l10_q)) << HALF_W) + WIDE_W'(l00_q);
    csq_q <= (WIDE_W'(c11_q) << (2 * HALF_W))
           + ((WIDE_W'(c01_q) + WIDE_W'(c10_q)) << HALF_W) + WIDE_W'(c00_q);
  end

  assign tag_o = t5_q;
  assign lsq_o = lsq_q;
  assign csq_o = csq_q;

endmodule

/* design/vsc_divider.sv */
// Restoring divider, one quotient bit per stage: floor(csq * 2^32 / lsq).
module vsc_divider import vsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vsc_tag_t          tag_i,
  input  logic [WIDE_W-1:0] num_i,
  input  logic [WIDE_W-1:0] den_i,
  output vsc_tag_t          tag_o,
  output logic [QUOT_W-1:0] quot_o
);

  vsc_tag_t          tag_q [QUOT_W];
  logic [QUOT_W-1:0] quo_q [QUOT_W];
  logic [WIDE_W-1:0] rem_q [QUOT_W-1];
  logic [WIDE_W-1:0] den_q [QUOT_W-1];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic [WIDE_W-1:0] r_in, d_in;
    logic [QUOT_W-1:0] q_in;
    vsc_tag_t          t_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign r_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
      assign t_in = tag_i;
    end else begin : g_next
      assign r_in = {rem_q[k-1][WIDE_W-2:0], 1'b0};
      assign d_in = den_q[k-1];
      assign q_in = quo_q[k-1];
      assign t_in = tag_q[k-1];
    end

    assign ge = r_in >= d_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else begin
        tag_q[k] <= t_in;
      end
    end

    always_ff @(posedge clk_i) begin
      quo_q[k] <= {q_in[QUOT_W-2:0], ge};
    end

    if (k < QUOT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k] <= ge ? r_in - d_in : r_in;
        den_q[k] <= d_in;
      end
    end
  end

  assign tag_o  = tag_q[QUOT_W-1];
  assign quot_o = quo_q[QUOT_W-1];

endmodule

/* design/vsc_isqrt.sv */
// Integer square root, one root bit per stage, with a running square.
module vsc_isqrt import vsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vsc_tag_t          tag_i,
  input  logic [QUOT_W-1:0] rad_i,
  output vsc_tag_t          tag_o,
  output logic [SINE_W-1:0] root_o
);

  localparam int ACC_W = 2 * SINE_W + 1;

  vsc_tag_t          tag_q  [SINE_W];
  logic [SINE_W-1:0] root_q [SINE_W];
  logic [ACC_W-1:0]  sq_q   [SINE_W-1];
  logic [QUOT_W-1:0] rad_q  [SINE_W-1];

  for (genvar k = 0; k < SINE_W; k++) begin : g_stage
    localparam int B = SINE_W - 1 - k;
    logic [SINE_W-1:0] s_in;
    logic [ACC_W-1:0]  sq_in, cand_sq;
    logic [QUOT_W-1:0] r_in;
    vsc_tag_t          t_in;
    logic              take;

    if (k == 0) begin : g_first
      assign s_in  = '0;
      assign sq_in = '0;
      assign r_in  = rad_i;
      assign t_in  = tag_i;
    end else begin : g_next
      assign s_in  = root_q[k-1];
      assign sq_in = sq_q[k-1];
      assign r_in  = rad_q[k-1];
      assign t_in  = tag_q[k-1];
    end

    assign cand_sq = sq_in + (ACC_W'(s_in) << (B + 1)) + (ACC_W'(1) << (2 * B));
    assign take    = cand_sq <= ACC_W'(r_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else begin
        tag_q[k] <= t_in;
      end
    end

    always_ff @(posedge clk_i) begin
      root_q[k] <= take ? (s_in | (SINE_W'(1) << B)) : s_in;
    end

    if (k < SINE_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        sq_q[k]  <= take ? cand_sq : sq_in;
        rad_q[k] <= r_in;
      end
    end
  end

  assign tag_o  = tag_q[SINE_W-1];
  assign root_o = root_q[SINE_W-1];

endmodule

/* design/vsc_power.sv */
// Power curve: table lookup with linear interpolation, saturation, output scaling and zeroing of degenerate results.
module vsc_power import vsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vsc_tag_t          tag_i,
  input  logic [SINE_W-1:0] sine_i,
  output vsc_tag_t          tag_o,
  output logic [OUT_W-1:0]  contrast_o
);

  // stage 1: table position
  vsc_tag_t t1_q;
  logic [IDX_W-1:0]     i_q, j_q;
  logic [SINE_FRAC-1:0] f1_q;
  logic [P_W-1:0]       p_d;
  logic [IDX_W-1:0]     i_d;

  assign p_d = P_W'(sine_i) * P_W'(LAST_IDX);
  assign i_d = p_d[SINE_FRAC+IDX_W-1:SINE_FRAC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
    end else begin
      t1_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q  <= i_d;
    j_q  <= (i_d == LAST_IDX) ? i_d : i_d + IDX_W'(1);
    f1_q <= p_d[SINE_FRAC-1:0];
  end

  // stage 2: lookup
  vsc_tag_t t2_q;
  logic [TAB_W-1:0]     ti2_q, tj2_q;
  logic [SINE_FRAC-1:0] f2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t2_q <= '0;
    end else begin
      t2_q <= t1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ti2_q <= POW_TABLE[i_q];
    tj2_q <= POW_TABLE[j_q];
    f2_q  <= f1_q;
  end

  // stage 3: slope times fraction
  vsc_tag_t t3_q;
  logic [TAB_W-1:0]           ti3_q;
  logic [TAB_W+SINE_FRAC-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t3_q <= '0;
    end else begin
      t3_q <= t2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ti3_q  <= ti2_q;
    prod_q <= (TAB_W+SINE_FRAC)'(tj2_q - ti2_q) * (TAB_W+SINE_FRAC)'(f2_q);
  end

  // stage 4: sum, saturate, scale, zero degenerate results
  vsc_tag_t t4_q;
  logic [OUT_W-1:0] res_q;
  logic [TAB_W-1:0] r_d, sat_d;
  logic [OUT_W-1:0] scaled_d;

  assign r_d   = ti3_q + prod_q[TAB_W+SINE_FRAC-1:SINE_FRAC];
  assign sat_d = (r_d > RES_MAX) ? RES_MAX : r_d;

  if (RESULT_FRACTION_BITS >= OUT_W) begin : g_down
    assign scaled_d = sat_d[RESULT_FRACTION_BITS-1 -: OUT_W];
  end else begin : g_up
    assign scaled_d = {sat_d[RESULT_FRACTION_BITS-1:0], {(OUT_W-RESULT_FRACTION_BITS){1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t4_q <= '0;
    end else begin
      t4_q <= t3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= t3_q.degen ? '0 : scaled_d;
  end

  assign tag_o      = t4_q;
  assign contrast_o = res_q;

endmodule
